>>> hdl/pefp_pkg.sv
`default_nettype none
package pefp_pkg;

  typedef struct packed {
    logic signed [31:0] p0_x;
    logic signed [31:0] p0_y;
    logic signed [31:0] p0_z;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p1_z;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p2_z;
    logic [7:0]         face_kind;
  } tri_t;

  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [63:0] offset_d;
    logic [7:0]         face_kind_out;
    logic               degenerate;
  } plane_t;

  // vertex and tag that ride along the pipeline
  typedef struct packed {
    logic [2:0][31:0] p0;
    logic [7:0]       kind;
  } keep_t;

  // per-item side data after block scaling
  typedef struct packed {
    logic [2:0][30:0] n;
    logic [2:0]       neg;
    logic             degen;
    keep_t            keep;
  } side_t;

  localparam int SumW  = 64;
  localparam int RootW = 32;
  localparam int NW    = 31;

endpackage
`default_nettype wire

>>> hdl/pefp_front.sv
`default_nettype none
module pefp_front
  import pefp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  tri_t              tri_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [SumW-1:0]   sum_o,
  output side_t             side_o
);

  localparam int Stages = 7;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   en;

  always_comb begin
    en[Stages] = ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[Stages-1];

  logic [2:0][31:0] p0, p1, p2;
  assign p0 = {tri_i.p0_x, tri_i.p0_y, tri_i.p0_z};
  assign p1 = {tri_i.p1_x, tri_i.p1_y, tri_i.p1_z};
  assign p2 = {tri_i.p2_x, tri_i.p2_y, tri_i.p2_z};

  keep_t keep_q [4];

  // stage 1: edge vectors; in the packed vertices index 2 is x, 0 is z
  logic signed [32:0] e0_q [3];
  logic signed [32:0] e1_q [3];
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        e0_q[i] <= {p2[2-i][31], p2[2-i]} - {p1[2-i][31], p1[2-i]};
        e1_q[i] <= {p0[2-i][31], p0[2-i]} - {p1[2-i][31], p1[2-i]};
      end
      keep_q[0] <= '{p0: p0, kind: tri_i.face_kind};
    end
  end

  // stage 2: six partial products (e index 0=x,1=y,2=z)
  logic signed [65:0] pr_q [6];
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pr_q[0] <= e0_q[1] * e1_q[2];
      pr_q[1] <= e0_q[2] * e1_q[1];
      pr_q[2] <= e0_q[2] * e1_q[0];
      pr_q[3] <= e0_q[0] * e1_q[2];
      pr_q[4] <= e0_q[0] * e1_q[1];
      pr_q[5] <= e0_q[1] * e1_q[0];
      keep_q[1] <= keep_q[0];
    end
  end

  // stage 3: cross product, exact
  logic signed [66:0] c_q [3];
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= {pr_q[2*i][65], pr_q[2*i]} - {pr_q[2*i+1][65], pr_q[2*i+1]};
      end
      keep_q[2] <= keep_q[1];
    end
  end

  // stage 4: sign and magnitude
  logic [65:0] mag_q [3];
  logic [2:0]  neg_q;
  logic [66:0] cneg [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cneg[i] = 67'(-c_q[i]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i]  <= c_q[i][66] ? cneg[i][65:0] : c_q[i][65:0];
        neg_q[2-i] <= c_q[i][66];
      end
      keep_q[3] <= keep_q[2];
    end
  end

  // stage 5: block scaling to 31 significant bits
  logic [65:0] orall;
  logic [6:0]  tlen;
  logic [65:0] shv [3];
  logic [2:0][30:0] n_d;
  always_comb begin
    orall = mag_q[0] | mag_q[1] | mag_q[2];
    tlen  = '0;
    for (int b = 0; b < 66; b++) begin
      if (orall[b]) tlen = 7'(b + 1);
    end
    for (int i = 0; i < 3; i++) begin
      if (tlen > 7'd31) shv[i] = mag_q[i] >> (tlen - 7'd31);
      else              shv[i] = mag_q[i] << (7'd31 - tlen);
      n_d[2-i] = shv[i][30:0];
    end
  end

  side_t side5_q, side6_q, side7_q;
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      side5_q <= '{n: n_d, neg: neg_q, degen: (tlen == '0), keep: keep_q[3]};
    end
  end

  // stage 6: squares
  logic [61:0] sq_q [3];
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= side5_q.n[i] * side5_q.n[i];
      end
      side6_q <= side5_q;
    end
  end

  // stage 7: sum of squares
  logic [SumW-1:0] sum_q;
  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      sum_q   <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      side7_q <= side6_q;
    end
  end

  assign sum_o  = sum_q;
  assign side_o = side7_q;

endmodule
`default_nettype wire

>>> hdl/pefp_sqrt.sv
`default_nettype none
module pefp_sqrt
  import pefp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [SumW-1:0]  sum_i,
  input  side_t            side_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [RootW-1:0] root_o,
  output side_t            side_o
);

  localparam int Stages = RootW;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   en;

  always_comb begin
    en[Stages] = ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[Stages-1];

  logic [RootW+2:0]  rem_q  [Stages];
  logic [RootW-1:0]  root_q [Stages];
  logic [SumW-1:0]   rad_q  [Stages];
  side_t             side_q [Stages];

  // one root bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < Stages; k++) begin : g_step
    logic [RootW+2:0] rem_p, rem_s;
    logic [RootW-1:0] root_p;
    logic [SumW-1:0]  rad_p;
    side_t            side_p;
    logic [RootW+1:0] trial;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = sum_i;
      assign side_p = side_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign side_p = side_q[k-1];
    end

    assign rem_s = {rem_p[RootW:0], rad_p[SumW-1:SumW-2]};
    assign trial = {root_p, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        if (rem_s >= (RootW+3)'(trial)) begin
          rem_q[k]  <= rem_s - (RootW+3)'(trial);
          root_q[k] <= {root_p[RootW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_s;
          root_q[k] <= {root_p[RootW-2:0], 1'b0};
        end
        rad_q[k]  <= {rad_p[SumW-3:0], 2'b00};
        side_q[k] <= side_p;
      end
    end
  end

  assign root_o = root_q[Stages-1];
  assign side_o = side_q[Stages-1];

endmodule
`default_nettype wire

>>> hdl/pefp_div.sv
`default_nettype none
module pefp_div
  import pefp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [RootW-1:0] root_i,
  input  side_t            side_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [2:0][NW-1:0] quo_o,
  output side_t            side_o
);

  localparam int Stages = NW;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   en;

  always_comb begin
    en[Stages] = ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[Stages-1];

  // rounded numerator n*2^30 + m/2
  logic [2*NW-1:0] num [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {side_i.n[i], 31'd0} >> 1;
      num[i] = num[i] + (2*NW)'(root_i >> 1);
    end
  end

  logic [RootW-1:0]      rem_q  [Stages][3];
  logic [NW-1:0]         quo_q  [Stages][3];
  logic [NW-1:0]         low_q  [Stages][3];
  logic [RootW-1:0]      m_q    [Stages];
  side_t                 side_q [Stages];

  // one quotient bit per stage for each of the three lanes
  for (genvar k = 0; k < Stages; k++) begin : g_step
    logic [RootW-1:0] m_p;
    side_t            side_p;
    logic [RootW-1:0] rem_p [3];
    logic [NW-1:0]    quo_p [3];
    logic [NW-1:0]    low_p [3];
    logic [RootW:0]   rem_s [3];

    if (k == 0) begin : g_first
      assign m_p    = root_i;
      assign side_p = side_i;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_p[i] = RootW'(num[i][2*NW-1:NW]);
        assign quo_p[i] = '0;
        assign low_p[i] = num[i][NW-1:0];
      end
    end else begin : g_next
      assign m_p    = m_q[k-1];
      assign side_p = side_q[k-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_p[i] = rem_q[k-1][i];
        assign quo_p[i] = quo_q[k-1][i];
        assign low_p[i] = low_q[k-1][i];
      end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane_s
      assign rem_s[i] = {rem_p[i], low_p[i][NW-1]};
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_s[i] >= {1'b0, m_p}) begin
            rem_q[k][i] <= RootW'(rem_s[i] - {1'b0, m_p});
            quo_q[k][i] <= {quo_p[i][NW-2:0], 1'b1};
          end else begin
            rem_q[k][i] <= rem_s[i][RootW-1:0];
            quo_q[k][i] <= {quo_p[i][NW-2:0], 1'b0};
          end
          low_q[k][i] <= {low_p[i][NW-2:0], 1'b0};
        end
        m_q[k]    <= m_p;
        side_q[k] <= side_p;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo_o[i] = quo_q[Stages-1][i];
    end
  end
  assign side_o = side_q[Stages-1];

endmodule
`default_nettype wire

>>> hdl/plane_equation_from_triangle_core.sv
// Triangle set-up: plane equation from three vertices.
// Input channel in_valid_i / in_ready_o / in_data_i carries three Q16.16
// vertices and a face tag; a transfer happens when valid and ready are high.
// Output channel out_valid_o / out_ready_i / out_data_o carries the unit
// normal (Q2.30), the offset D (Q34.30), the tag and a degenerate flag.
// One result leaves for every triangle taken, in order.
// Each triangle passes through edges, cross product, block scaling and sum of
// squares, then the one-bit-per-stage square root, then the three
// one-bit-per-stage dividers and last sign, dot product and rounding.
// Throughput is one triangle per cycle unless stalled; every stage is a
// register with its own valid bit, so the pipeline keeps filling behind a
// stalled result. When out_ready_i is low the item in the output register
// holds and each stage stops only once the stage after it is full; nothing
// is dropped or repeated. Reset clears all valid bits; no result is pending
// after it. A collinear triangle gives zero coefficients with degenerate set.
`default_nettype none
module plane_equation_from_triangle_core
  import pefp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  tri_t   in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output plane_t out_data_o
);

  logic             f_valid, f_ready;
  logic [SumW-1:0]  f_sum;
  side_t            f_side;
  logic             s_valid, s_ready;
  logic [RootW-1:0] s_root;
  side_t            s_side;
  logic             d_valid, d_ready;
  logic [2:0][NW-1:0] d_quo;
  side_t            d_side;

  pefp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .tri_i   (in_data_i),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .sum_o   (f_sum),
    .side_o  (f_side)
  );

  pefp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .sum_i   (f_sum),
    .side_i  (f_side),
    .valid_o (s_valid),
    .ready_i (s_ready),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  pefp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .ready_o (s_ready),
    .root_i  (s_root),
    .side_i  (s_side),
    .valid_o (d_valid),
    .ready_i (d_ready),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  localparam int Stages = 3;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   en;

  always_comb begin
    en[Stages] = out_ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= d_valid;
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign d_ready = en[0];

  // stage 1: signed normal, forced to zero for a degenerate triangle
  logic signed [31:0] nrm_q [3];
  keep_t              keep1_q, keep2_q;
  logic               degen1_q, degen2_q;
  logic [31:0]        qext [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qext[i] = {1'b0, d_quo[i]};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        if (d_side.degen)        nrm_q[i] <= '0;
        else if (d_side.neg[i])  nrm_q[i] <= -qext[i];
        else                     nrm_q[i] <= qext[i];
      end
      keep1_q  <= d_side.keep;
      degen1_q <= d_side.degen;
    end
  end

  // stage 2: normal times first vertex
  logic signed [63:0] prod_q [3];
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= nrm_q[i] * $signed(keep1_q.p0[i]);
      end
      keep2_q  <= keep1_q;
      degen2_q <= degen1_q;
    end
  end

  // stage 3: D = -(dot) in Q18.46, rounded to Q34.30
  logic signed [65:0] dot, rnd;
  always_comb begin
    dot = 66'(prod_q[0]) + 66'(prod_q[1]) + 66'(prod_q[2]);
    rnd = -dot + 66'sd32768;
  end

  // the dot product trails the normals by one stage, so keep a copy
  logic signed [31:0] nrm2_q [3];
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        nrm2_q[i] <= nrm_q[i];
      end
    end
  end

  // lane 2 is x, lane 0 is z
  plane_t out_q;
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      out_q.normal_x      <= nrm2_q[2];
      out_q.normal_y      <= nrm2_q[1];
      out_q.normal_z      <= nrm2_q[0];
      out_q.offset_d      <= 64'(rnd >>> 16);
      out_q.face_kind_out <= keep2_q.kind;
      out_q.degenerate    <= degen2_q;
    end
  end

  assign out_valid_o = v_q[Stages-1];
  always_comb begin
    out_data_o          = out_q;
    out_data_o.normal_x = out_q.normal_x;
  end

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import pefp_pkg::*;

  localparam int Latency = 73;
  localparam int WatchLimit = 20000;

  typedef struct {
    logic neg;
    logic [127:0] mag;
  } wide_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  tri_t   in_data = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  plane_t out_data;

  tri_t   pending_tris[$];
  plane_t plane_q[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     in_gap = 0;
  int     out_gap = 0;
  bit     stim_done = 1'b0;
  bit     drain_hold = 1'b0;
  bit     in_flight = 1'b0;
  bit     in_ready_seen = 1'b0;

  plane_equation_from_triangle_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  function automatic wide_t edge_cross(longint a, longint b, longint c, longint d);
    logic signed [127:0] p;
    wide_t r;
    p = 128'(signed'(a)) * 128'(signed'(b)) - 128'(signed'(c)) * 128'(signed'(d));
    r.neg = p[127];
    r.mag = p[127] ? -p : p;
    return r;
  endfunction

  function automatic int bit_len(logic [127:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic plane_t plane_of(tri_t t);
    longint p0[3], p1[3], p2[3], e0[3], e1[3];
    wide_t c[3];
    logic [63:0] n[3], sum, m, q;
    logic signed [63:0] nrm[3], acc, u;
    int tl, b;
    plane_t r;
    p0 = '{longint'(t.p0_x), longint'(t.p0_y), longint'(t.p0_z)};
    p1 = '{longint'(t.p1_x), longint'(t.p1_y), longint'(t.p1_z)};
    p2 = '{longint'(t.p2_x), longint'(t.p2_y), longint'(t.p2_z)};
    for (int i = 0; i < 3; i++) begin
      e0[i] = p2[i] - p1[i];
      e1[i] = p0[i] - p1[i];
    end
    c[0] = edge_cross(e0[1], e1[2], e0[2], e1[1]);
    c[1] = edge_cross(e0[2], e1[0], e0[0], e1[2]);
    c[2] = edge_cross(e0[0], e1[1], e0[1], e1[0]);
    tl = 0;
    for (int i = 0; i < 3; i++) begin
      b = bit_len(c[i].mag);
      if (b > tl) tl = b;
    end
    r = '0;
    r.face_kind_out = t.face_kind;
    if (tl == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = (tl > 31) ? 64'(c[i].mag >> (tl - 31)) : 64'(c[i].mag << (31 - tl));
      sum += n[i] * n[i];
    end
    m = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((n[i] << 30) + (m >> 1)) / m;
      nrm[i] = c[i].neg ? -$signed(q) : $signed(q);
    end
    acc = nrm[0] * p0[0] + nrm[1] * p0[1] + nrm[2] * p0[2];
    acc = -acc;
    u = acc + 64'sh8000;
    r.offset_d = u >>> 16;
    r.normal_x = nrm[0][31:0];
    r.normal_y = nrm[1][31:0];
    r.normal_z = nrm[2][31:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return 32'($signed($urandom_range(0, 20'hfffff)) - 20'h80000) << 10;
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    t.p0_x = rand_coord(); t.p0_y = rand_coord(); t.p0_z = rand_coord();
    t.p1_x = rand_coord(); t.p1_y = rand_coord(); t.p1_z = rand_coord();
    t.p2_x = rand_coord(); t.p2_y = rand_coord(); t.p2_z = rand_coord();
    t.face_kind = $urandom();
    case ($urandom_range(0, 9))
      0: begin  // coincident or collinear points
        t.p1_x = t.p0_x; t.p1_y = t.p0_y; t.p1_z = t.p0_z;
      end
      1: begin
        t.p2_x = t.p0_x + (t.p0_x - t.p1_x);
        t.p2_y = t.p0_y + (t.p0_y - t.p1_y);
        t.p2_z = t.p0_z + (t.p0_z - t.p1_z);
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic tri_t mk_tri(logic [31:0] a0, a1, a2, b0, b1, b2,
                                  c0, c1, c2, logic [7:0] k);
    tri_t t;
    t = '{a0, a1, a2, b0, b1, b2, c0, c1, c2, k};
    return t;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    pending_tris.push_back(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00));
    pending_tris.push_back(mk_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 8'hff));
    pending_tris.push_back(mk_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                  32'h80000000, 32'h80000000, 32'h7fffffff,
                                  32'h7fffffff, 32'h80000000, 32'h80000000, 8'h55));
    pending_tris.push_back(mk_tri(32'h80000000, 32'h80000000, 32'h80000000,
                                  32'h7fffffff, 32'h80000000, 32'h80000000,
                                  32'h80000000, 32'h7fffffff, 32'h7fffffff, 8'haa));
    pending_tris.push_back(mk_tri(1, 2, 3, 2, 4, 6, 3, 6, 9, 8'h01));
    pending_tris.push_back(mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 8'h80));
    pending_tris.push_back(mk_tri(32'hffffffff, 0, 0, 0, 32'hffffffff, 0, 0, 0,
                                  32'hffffffff, 8'h7f));
    pending_tris.push_back(mk_tri(5, 5, 5, 5, 5, 5, 5, 5, 5, 8'h12));
    pending_tris.push_back(mk_tri(32'h7fffffff, 0, 0, 32'h80000000, 0, 0,
                                  0, 32'h7fffffff, 32'h7fffffff, 8'h34));
    for (int i = 0; i < 1400; i++) pending_tris.push_back(rand_tri());
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_flight && in_ready_seen) begin
        in_flight = 1'b0;
      end
      if (!in_flight) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (drain_hold) begin
          in_valid <= 1'b0;
          if (plane_q.size() == 0) drain_hold = 1'b0;
        end else if (pending_tris.size() > 0) begin
          in_data <= pending_tris.pop_front();
          in_valid <= 1'b1;
          in_flight = 1'b1;
          in_gap = pick_gap();
          if (pending_tris.size() == 700) drain_hold = 1'b1;
        end else begin
          in_valid <= 1'b0;
          stim_done = 1'b1;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    plane_t exp_plane;
    in_ready_seen = 1'b0;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && in_ready) begin
        in_ready_seen = 1'b1;
        plane_q.push_back(plane_of(in_data));
        idle_cycles = 0;
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (plane_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer %p", out_data);
        end else begin
          exp_plane = plane_q.pop_front();
          if (out_data !== exp_plane) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", exp_plane, out_data);
          end
        end
      end
      if (idle_cycles >= WatchLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (plane_q.size() == 0);
    repeat (Latency * 2) @(posedge clk);
    if (mismatches == 0 && plane_q.size() == 0 && !out_valid) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
